/* hw/rtl/ryc_pkg.sv */
// Shared types and constants for the RGB to YCbCr 4:2:0 converter.
// Depends on nothing; the line store, colour arithmetic and top level refer to it by scoped names.
`timescale 1ns / 1ps

package ryc_pkg;

    // Frame geometry and the defaults that reset loads.
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_W         = 12;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // BT.601 coefficients in Q16.
    localparam logic [15:0] COEF_Y_R  = 16'd16843;
    localparam logic [15:0] COEF_Y_G  = 16'd33030;
    localparam logic [15:0] COEF_Y_B  = 16'd6423;
    localparam logic [15:0] COEF_CB_R = 16'd9699;
    localparam logic [15:0] COEF_CB_G = 16'd19071;
    localparam logic [15:0] COEF_C_HI = 16'd28770;
    localparam logic [15:0] COEF_CR_G = 16'd24117;
    localparam logic [15:0] COEF_CR_B = 16'd4653;

    localparam logic [7:0]  LUMA_OFFSET   = 8'd16;
    localparam logic [23:0] CHROMA_OFFSET = 24'd8388608;

    // One pixel, red in the low byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    // Horizontal pair sums of one channel triple, red in the low bits.
    typedef struct packed {
        logic [8:0] blue;
        logic [8:0] green;
        logic [8:0] red;
    } t_pair_sum;

    // Contents of the first pipeline stage, handed to the colour arithmetic.
    typedef struct packed {
        t_rgb      pixel;
        t_pair_sum pair;
        logic      chroma;
        logic      frame_end;
    } t_stage0;

endpackage

/* hw/rtl/ryc_pixel_if.sv */
// Input channel of the converter: one RGB pixel per transaction.
// Depends on nothing.
`timescale 1ns / 1ps

interface ryc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/ryc_yuv_if.sv */
// Output channel of the converter: luma of one pixel, with block chroma when complete.
// Depends on nothing.
`timescale 1ns / 1ps

interface ryc_yuv_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] blue_difference;
    logic [7:0] red_difference;
    logic       frame_end;

    modport source (output valid, output luma, output chroma_valid,
                    output blue_difference, output red_difference,
                    output frame_end, input ready);
    modport sink   (input valid, input luma, input chroma_valid,
                    input blue_difference, input red_difference,
                    input frame_end, output ready);
endinterface

/* hw/rtl/ryc_line_store.sv */
// Line store holding the even row's horizontal pair sums, one entry per column pair.
// Single synchronous memory with a registered read; depends on ryc_pkg.
`timescale 1ns / 1ps

module ryc_line_store #(
    parameter int MAX_WIDTH = ryc_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic                             i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-2:0]     i_addr,
    input  ryc_pkg::t_pair_sum               i_wr_data,
    output ryc_pkg::t_pair_sum               o_rd_data
);

    localparam int DEPTH = (MAX_WIDTH + 1) / 2;

    ryc_pkg::t_pair_sum mem [DEPTH];
    ryc_pkg::t_pair_sum r_rd_data;

    // Write on even rows, read on odd rows; one access per column pair.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/ryc_color_math.sv */
// Colour arithmetic pipeline: 2x2 averaging, luma and chroma products, sums and offsets.
// Three stages, the last being the output register; depends on ryc_pkg and ryc_yuv_if.
`timescale 1ns / 1ps

module ryc_color_math (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s0_valid,
    input  ryc_pkg::t_stage0   i_s0,
    input  ryc_pkg::t_pair_sum i_rd_data,
    output logic               o_s0_ready,
    ryc_yuv_if.source          o_yuv
);

    // Stage valids and per-stage load enables; a stage loads when it is empty
    // or when the stage after it loads, so bubbles are squeezed out.
    logic r_v1, r_v2, r_v3;
    logic load1, load2, load3;

    assign load3 = !r_v3 || o_yuv.ready;
    assign load2 = !r_v2 || load3;
    assign load1 = !r_v1 || load2;
    assign o_s0_ready = load1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load1) begin
                r_v1 <= i_s0_valid;
            end
            if (load2) begin
                r_v2 <= r_v1;
            end
            if (load3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: block averages and the three luma products.
    logic [7:0]  n_avg_r, n_avg_g, n_avg_b;
    logic [9:0]  sum4_r, sum4_g, sum4_b;
    logic [23:0] n_py_r, n_py_g, n_py_b;
    logic [7:0]  r_avg_r, r_avg_g, r_avg_b;
    logic [23:0] r_py_r, r_py_g, r_py_b;
    logic        r_c1, r_fe1;

    always_comb begin
        sum4_r  = 10'(i_s0.pair.red)   + 10'(i_rd_data.red);
        sum4_g  = 10'(i_s0.pair.green) + 10'(i_rd_data.green);
        sum4_b  = 10'(i_s0.pair.blue)  + 10'(i_rd_data.blue);
        n_avg_r = sum4_r[9:2];
        n_avg_g = sum4_g[9:2];
        n_avg_b = sum4_b[9:2];
        n_py_r  = 24'(i_s0.pixel.red)   * 24'(ryc_pkg::COEF_Y_R);
        n_py_g  = 24'(i_s0.pixel.green) * 24'(ryc_pkg::COEF_Y_G);
        n_py_b  = 24'(i_s0.pixel.blue)  * 24'(ryc_pkg::COEF_Y_B);
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_avg_r <= n_avg_r;
            r_avg_g <= n_avg_g;
            r_avg_b <= n_avg_b;
            r_py_r  <= n_py_r;
            r_py_g  <= n_py_g;
            r_py_b  <= n_py_b;
            r_c1    <= i_s0.chroma;
            r_fe1   <= i_s0.frame_end;
        end
    end

    // Stage 2: luma sum with offset, and the six chroma products.
    logic [23:0] luma_sum;
    logic [7:0]  n_luma;
    logic [22:0] n_pcb_r, n_pcb_g, n_pcb_b, n_pcr_r, n_pcr_g, n_pcr_b;
    logic [7:0]  r_luma2;
    logic [22:0] r_pcb_r, r_pcb_g, r_pcb_b, r_pcr_r, r_pcr_g, r_pcr_b;
    logic        r_c2, r_fe2;

    always_comb begin
        luma_sum = r_py_r + r_py_g + r_py_b;
        n_luma   = luma_sum[23:16] + ryc_pkg::LUMA_OFFSET;
        n_pcb_r  = 23'(r_avg_r) * 23'(ryc_pkg::COEF_CB_R);
        n_pcb_g  = 23'(r_avg_g) * 23'(ryc_pkg::COEF_CB_G);
        n_pcb_b  = 23'(r_avg_b) * 23'(ryc_pkg::COEF_C_HI);
        n_pcr_r  = 23'(r_avg_r) * 23'(ryc_pkg::COEF_C_HI);
        n_pcr_g  = 23'(r_avg_g) * 23'(ryc_pkg::COEF_CR_G);
        n_pcr_b  = 23'(r_avg_b) * 23'(ryc_pkg::COEF_CR_B);
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_luma2 <= n_luma;
            r_pcb_r <= n_pcb_r;
            r_pcb_g <= n_pcb_g;
            r_pcb_b <= n_pcb_b;
            r_pcr_r <= n_pcr_r;
            r_pcr_g <= n_pcr_g;
            r_pcr_b <= n_pcr_b;
            r_c2    <= r_c1;
            r_fe2   <= r_fe1;
        end
    end

    // Stage 3: signed chroma sums, floor to eight bits, output register.
    logic signed [26:0] cb_sum, cr_sum;
    logic [7:0]         n_cb, n_cr;
    logic [7:0]         r_luma3, r_cb3, r_cr3;
    logic               r_c3, r_fe3;

    always_comb begin
        cb_sum = signed'(27'(ryc_pkg::CHROMA_OFFSET)) + signed'(27'(r_pcb_b))
               - signed'(27'(r_pcb_r)) - signed'(27'(r_pcb_g));
        cr_sum = signed'(27'(ryc_pkg::CHROMA_OFFSET)) + signed'(27'(r_pcr_r))
               - signed'(27'(r_pcr_g)) - signed'(27'(r_pcr_b));
        n_cb = (r_c2 && !cb_sum[26]) ? cb_sum[23:16] : 8'd0;
        n_cr = (r_c2 && !cr_sum[26]) ? cr_sum[23:16] : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (load3) begin
            r_luma3 <= r_luma2;
            r_cb3   <= n_cb;
            r_cr3   <= n_cr;
            r_c3    <= r_c2;
            r_fe3   <= r_fe2;
        end
    end

    assign o_yuv.valid           = r_v3;
    assign o_yuv.luma            = r_luma3;
    assign o_yuv.chroma_valid    = r_c3;
    assign o_yuv.blue_difference = r_cb3;
    assign o_yuv.red_difference  = r_cr3;
    assign o_yuv.frame_end       = r_fe3;

`ifndef SYNTHESIS
    // Chroma samples are zero on every transaction that carries no chroma.
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_yuv.valid && !o_yuv.chroma_valid) |->
        (o_yuv.blue_difference == 8'd0 && o_yuv.red_difference == 8'd0))
        else $error("chroma not zero on a luma-only transaction");

    // The front may only be held off when every stage is full and the output stalls.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s0_ready |-> (r_v1 && r_v2 && r_v3 && !o_yuv.ready))
        else $error("front stalled while the pipeline has room");
`endif

endmodule

/* hw/rtl/rgb_to_yuv420_converter.sv */
// Top level of the RGB to YCbCr 4:2:0 converter: configuration, counters, front stage.
// Depends on ryc_pkg, ryc_pixel_if, ryc_yuv_if, ryc_line_store and ryc_color_math.
//
//  Channel  | Direction | Transaction
//  ---------+-----------+------------------------------------------------------
//  i_pixel  | in        | one RGB pixel, raster order
//  o_yuv    | out       | luma of that pixel, chroma on a 2x2 block's last pixel
//  i_cfg_*  | in        | register write: frame_width (0), frame_height (1)
//
// One pixel is accepted per clock while the pipeline has room; its result passes through the front
// stage register and the three colour stages. The line store takes one access per column pair.
// Reset is synchronous and active low; it loads 640 x 480 and clears the counters.
// The line store needs no clearing: odd rows only read pairs that the even row wrote.
// A stalled output register holds; empty stages behind it keep filling before input stops.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter #(
    parameter int MAX_WIDTH = ryc_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ryc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ryc_pkg::CFG_W-1:0]     i_cfg_data,
    ryc_pixel_if.sink                     i_pixel,
    ryc_yuv_if.source                     o_yuv
);

    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int ADDR_W = CNT_W - 1;
    localparam int LW     = (CNT_W + 1 > ryc_pkg::CFG_W) ? CNT_W + 1 : ryc_pkg::CFG_W;
    localparam int HW     = ryc_pkg::ROW_W + 1;

    // Configuration registers.
    logic [ryc_pkg::CFG_W-1:0] r_frame_width, r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ryc_pkg::WIDTH_RESET;
            r_frame_height <= ryc_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (ryc_pkg::t_cfg_reg'(i_cfg_index))
                ryc_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                ryc_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Dimensions in use: zero counts as one, large values stop at the limit.
    logic [LW-1:0] cfg_w, w_eff;
    logic [HW-1:0] cfg_h, h_eff;

    always_comb begin
        cfg_w = LW'(r_frame_width);
        if (cfg_w == '0) begin
            w_eff = LW'(1);
        end else if (cfg_w > LW'(MAX_WIDTH)) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = cfg_w;
        end
        cfg_h = HW'(r_frame_height);
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (r_frame_height > ryc_pkg::CFG_W'(ryc_pkg::HEIGHT_LIMIT)) begin
            h_eff = HW'(ryc_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = cfg_h;
        end
    end

    // Handshake of the front stage.
    logic r_s0_valid;
    logic s0_ready;
    logic in_ready;
    logic accept;

    assign in_ready      = !r_s0_valid || s0_ready;
    assign i_pixel.ready = in_ready;
    assign accept        = i_pixel.valid && in_ready;

    // Position counters and end-of-row / end-of-frame detection.
    logic [CNT_W-1:0]         r_col, n_col;
    logic [ryc_pkg::ROW_W-1:0] r_row, n_row;
    logic [LW-1:0]            col_next;
    logic [HW-1:0]            row_next;
    logic                     last_col, last_row;

    always_comb begin
        col_next = LW'(r_col) + LW'(1);
        row_next = HW'(r_row) + HW'(1);
        last_col = col_next >= w_eff;
        last_row = row_next >= h_eff;
        n_col    = r_col;
        n_row    = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : row_next[ryc_pkg::ROW_W-1:0];
        end else begin
            n_col = col_next[CNT_W-1:0];
        end
    end

    // Pair sums of the held even-column pixel and the incoming one.
    ryc_pkg::t_rgb      r_held;
    ryc_pkg::t_rgb      in_pixel;
    ryc_pkg::t_pair_sum pair;

    always_comb begin
        in_pixel.red   = i_pixel.red;
        in_pixel.green = i_pixel.green;
        in_pixel.blue  = i_pixel.blue;
        pair.red       = 9'(r_held.red)   + 9'(in_pixel.red);
        pair.green     = 9'(r_held.green) + 9'(in_pixel.green);
        pair.blue      = 9'(r_held.blue)  + 9'(in_pixel.blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0]) begin
                r_held <= in_pixel;
            end
        end
    end

    // Line store: even rows write pair sums, odd rows read them back.
    // Every access happens at an acceptance edge, in pixel order, so a read
    // never overlaps a write of the same entry and needs no forwarding.
    logic               ls_wr, ls_rd;
    ryc_pkg::t_pair_sum rd_data;

    assign ls_wr = accept && r_col[0] && !r_row[0];
    assign ls_rd = accept && r_col[0] &&  r_row[0];

    ryc_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (ls_wr),
        .i_rd_en   (ls_rd),
        .i_addr    (r_col[CNT_W-1:1]),
        .i_wr_data (pair),
        .o_rd_data (rd_data)
    );

    // Front stage register, aligned with the line store's read register.
    ryc_pkg::t_stage0 r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (in_ready) begin
            r_s0_valid <= i_pixel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s0.pixel     <= in_pixel;
            r_s0.pair      <= pair;
            r_s0.chroma    <= r_col[0] && r_row[0];
            r_s0.frame_end <= last_col && last_row;
        end
    end

    ryc_color_math u_color_math (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s0_valid (r_s0_valid),
        .i_s0       (r_s0),
        .i_rd_data  (rd_data),
        .o_s0_ready (s0_ready),
        .o_yuv      (o_yuv)
    );

`ifndef SYNTHESIS
    // The column count returns to zero after the last pixel of a row.
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col) |=> (r_col == '0))
        else $error("column count did not wrap at end of row");

    // Both counters are cleared after the last pixel of a frame.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last_col && last_row) |=> (r_col == '0 && r_row == '0))
        else $error("counters not cleared at end of frame");

    // An odd-column pixel pairs with the held pixel and leaves it untouched.
    a_held_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_col[0]) |=> $stable(r_held))
        else $error("held pixel changed on an odd column");

    // Address width tracks the store depth for any width limit.
    a_addr_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ls_wr |-> (32'(r_col[CNT_W-1:1]) < ((MAX_WIDTH + 1) / 2) && ADDR_W >= 1))
        else $error("line store address beyond depth");
`endif

endmodule
